FILE: src/hsl_pkg.sv
`timescale 1ns / 1ps
// shared types and constants of the http start line splitter
// no dependencies; imported by hsl_step and http_start_line_splitter
package hsl_pkg;

	localparam int OFS_W = 13;
	localparam logic [OFS_W-1:0] MAX_LINE = 13'd4096;

	localparam logic [7:0] CH_HT  = 8'h09;
	localparam logic [7:0] CH_LF  = 8'h0a;
	localparam logic [7:0] CH_CR  = 8'h0d;
	localparam logic [7:0] CH_SP  = 8'h20;
	localparam logic [7:0] CH_DEL = 8'h7f;

	// slots of the saved offsets
	localparam int F1_BEGIN = 0;
	localparam int F1_END   = 1;
	localparam int F2_BEGIN = 2;
	localparam int F2_END   = 3;
	localparam int F3_BEGIN = 4;
	localparam int F3_END   = 5;

	typedef enum logic [2:0] {
		PH_IDLE = 3'd0,
		PH_LEAD = 3'd1,
		PH_F1   = 3'd2,
		PH_GAP1 = 3'd3,
		PH_F2   = 3'd4,
		PH_GAP2 = 3'd5,
		PH_F3   = 3'd6,
		PH_DONE = 3'd7
	} phase_t;

	typedef struct packed {
		phase_t                  phase;
		logic [OFS_W-1:0]        ofs;
		logic                    pending_cr;
		logic [5:0][OFS_W-1:0]   saved;
		logic                    third_seen;
	} parse_state_t;

	typedef struct packed {
		logic             status;
		logic [OFS_W-1:0] field1_begin;
		logic [OFS_W-1:0] field1_end;
		logic [OFS_W-1:0] field2_begin;
		logic [OFS_W-1:0] field2_end;
		logic             field3_present;
		logic [OFS_W-1:0] field3_begin;
		logic [OFS_W-1:0] field3_end;
		logic [OFS_W-1:0] header_start;
	} line_res_t;

endpackage

FILE: src/http_start_line_splitter.sv
`timescale 1ns / 1ps
// top level of the http start line splitter: parse state and result register
// depends on hsl_pkg and hsl_step
//
// Takes one byte of a receive buffer per cycle (tuser marks the first byte,
// tlast the last) and splits the request start line into three fields. Each
// byte is handled in the cycle it is accepted; a buffer's single result, if any,
// appears in the output register the cycle after the deciding byte, and a
// byte can be taken every cycle. The only thing
// that holds input back is a result waiting in the output register while
// m_tready is low. Results with m_tuser set are bad requests and carry all
// offsets as zero; bytes after the result are dropped until the next buffer.
module http_start_line_splitter import hsl_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,  // [7:0] data_byte
	input  logic [0:0]  s_tuser,  // [0] first_byte
	input  logic        s_tlast,  // last_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	// [12:0] field1_begin, [25:13] field1_end, [38:26] field2_begin,
	// [51:39] field2_end, [52] field3_present, [65:53] field3_begin,
	// [78:66] field3_end, [91:79] header_start, [95:92] zero
	output logic [95:0] m_tdata,
	output logic [0:0]  m_tuser   // [0] status
);

	parse_state_t state_q;
	parse_state_t state_nxt;
	line_res_t    res_nxt;
	line_res_t    res_q;
	logic         emit;
	logic         out_valid_q;
	logic         in_acc;

	hsl_step u_step (
		.cur        (state_q),
		.data_byte  (s_tdata),
		.first_byte (s_tuser[0]),
		.last_byte  (s_tlast),
		.nxt        (state_nxt),
		.emit       (emit),
		.res        (res_nxt)
	);

	assign s_tready = !out_valid_q || m_tready;
	assign in_acc = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_acc) state_q <= state_nxt;
			if (in_acc && emit) out_valid_q <= 1'b1;
			else if (m_tready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc && emit) res_q <= res_nxt;
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser = res_q.status;
	assign m_tdata = {4'b0, res_q.header_start, res_q.field3_end, res_q.field3_begin,
		res_q.field3_present, res_q.field2_end, res_q.field2_begin,
		res_q.field1_end, res_q.field1_begin};

	// a bad request carries no offsets
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && res_q.status |-> m_tdata == '0)
		else $error("error result with nonzero offsets");

	// field three offsets are zero when the field is absent
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !res_q.status && !res_q.field3_present
			|-> res_q.field3_begin == '0 && res_q.field3_end == '0)
		else $error("absent field three with offsets");

	// a last byte of an open parse always yields a result
	assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && s_tlast && (s_tuser[0] ||
			(state_q.phase != PH_IDLE && state_q.phase != PH_DONE)) |=> m_tvalid)
		else $error("last byte of open line gave no result");

	// the header block starts past the end of field two
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !res_q.status |-> res_q.header_start > res_q.field2_end)
		else $error("header start not past field two");

endmodule

FILE: src/hsl_step.sv
`timescale 1ns / 1ps
// per-byte parse step: next parse state and the line result it may produce
// depends on hsl_pkg
module hsl_step import hsl_pkg::*; (
	input  parse_state_t cur,
	input  logic [7:0]   data_byte,
	input  logic         first_byte,
	input  logic         last_byte,
	output parse_state_t nxt,
	output logic         emit,
	output line_res_t    res
);

	function automatic logic is_ctl(input logic [7:0] c);
		return c inside {[8'h00:8'h1f], CH_DEL};
	endfunction

	function automatic logic is_sp(input logic [7:0] c);
		return c inside {CH_SP, CH_HT};
	endfunction

	function automatic logic is_lws(input logic [7:0] c);
		return c inside {CH_SP, CH_HT, CH_CR, CH_LF};
	endfunction

	parse_state_t     st;
	logic [OFS_W-1:0] o;
	logic             bad;
	logic             ok;
	logic             do_third;

	always_comb begin
		st = cur;
		if (first_byte) begin
			st = '0;
			st.phase = PH_LEAD;
		end
		nxt = st;
		o = st.ofs;
		bad = 1'b0;
		ok = 1'b0;
		do_third = 1'b0;
		emit = 1'b0;
		res = '0;

		if (st.phase != PH_IDLE && st.phase != PH_DONE) begin
			if (o >= MAX_LINE) begin
				bad = 1'b1;
			end else begin
				nxt.ofs = o + 1'b1;
				case (st.phase)
					PH_LEAD: begin
						if (!is_lws(data_byte)) begin
							nxt.saved[F1_BEGIN] = o;
							if (is_ctl(data_byte)) bad = 1'b1;
							else nxt.phase = PH_F1;
						end
					end
					PH_F1: begin
						if (is_sp(data_byte)) begin
							nxt.saved[F1_END] = o;
							nxt.phase = PH_GAP1;
						end else if (is_ctl(data_byte)) begin
							bad = 1'b1;
						end
					end
					PH_GAP1: begin
						if (data_byte != CH_SP) begin
							nxt.saved[F2_BEGIN] = o;
							if (is_lws(data_byte) || is_ctl(data_byte)) bad = 1'b1;
							else nxt.phase = PH_F2;
						end
					end
					PH_F2: begin
						if (is_lws(data_byte)) begin
							nxt.saved[F2_END] = o;
							if (data_byte == CH_SP) begin
								nxt.phase = PH_GAP2;
							end else if (data_byte == CH_HT) begin
								bad = 1'b1;
							end else begin
								// cr or lf ends field two straight into the terminator
								nxt.saved[F3_BEGIN] = o;
								nxt.phase = PH_F3;
								do_third = 1'b1;
							end
						end else if (is_ctl(data_byte)) begin
							bad = 1'b1;
						end
					end
					PH_GAP2: begin
						if (data_byte == CH_HT) begin
							bad = 1'b1;
						end else if (data_byte != CH_SP) begin
							nxt.saved[F3_BEGIN] = o;
							nxt.phase = PH_F3;
							do_third = 1'b1;
						end
					end
					default: do_third = 1'b1;
				endcase

				if (do_third) begin
					if (st.pending_cr) begin
						nxt.pending_cr = 1'b0;
						if (data_byte == CH_LF) begin
							nxt.saved[F3_END] = o - 1'b1;
							ok = 1'b1;
						end else begin
							bad = 1'b1;
						end
					end else if (data_byte == CH_LF) begin
						nxt.saved[F3_END] = o;
						ok = 1'b1;
					end else if (data_byte == CH_CR) begin
						nxt.pending_cr = 1'b1;
					end else if (is_ctl(data_byte) && !is_sp(data_byte)) begin
						bad = 1'b1;
					end else begin
						nxt.third_seen = 1'b1;
					end
				end
			end

			if (ok) begin
				emit = 1'b1;
				nxt.phase = PH_DONE;
				res.field1_begin = nxt.saved[F1_BEGIN];
				res.field1_end = nxt.saved[F1_END];
				res.field2_begin = nxt.saved[F2_BEGIN];
				res.field2_end = nxt.saved[F2_END];
				res.field3_present = nxt.third_seen;
				if (nxt.third_seen) begin
					res.field3_begin = nxt.saved[F3_BEGIN];
					res.field3_end = nxt.saved[F3_END];
				end
				res.header_start = o + 1'b1;
			end else if (bad || last_byte) begin
				emit = 1'b1;
				nxt.phase = PH_DONE;
				res.status = 1'b1;
			end
		end
	end

endmodule

FILE: tb/sv/tb_http_start_line_splitter.sv
`timescale 1ns / 1ps
// testbench of http_start_line_splitter: byte-stream driver, result checker
// depends on hsl_pkg and the block itself; predicts every result on its own
module tb_http_start_line_splitter;
	import hsl_pkg::*;

	localparam int CYCLE_LIMIT = 500000;
	localparam int RX_HOLD     = 400;
	localparam int FEED_TARGET = 1450;

	typedef enum {V_MORE, V_BAD, V_OK} verdict_t;
	typedef enum {RX_FREE, RX_COIN, RX_SPARSE, RX_MOSTLY} rx_mode_t;

	// expected start-line results, built byte by byte as the block takes them
	class line_board;
		phase_t           phase;
		logic [OFS_W-1:0] ofs;
		logic             cr_wait;
		logic [OFS_W-1:0] marks [6];
		logic             f3_nonempty;
		line_res_t        lines_due [$];
		int               errors;
		int               n_ok;
		int               n_bad;
		int               n_checked;

		function new();
			phase = PH_IDLE;
			clear();
			errors = 0;
			n_ok = 0;
			n_bad = 0;
			n_checked = 0;
		endfunction

		function void clear();
			ofs = '0;
			cr_wait = 1'b0;
			f3_nonempty = 1'b0;
			foreach (marks[i]) marks[i] = '0;
		endfunction

		function bit is_ctl(logic [7:0] c);
			return c < 8'h20 || c == CH_DEL;
		endfunction

		function bit is_sp(logic [7:0] c);
			return c == CH_SP || c == CH_HT;
		endfunction

		function bit is_lws(logic [7:0] c);
			return is_sp(c) || c == CH_CR || c == CH_LF;
		endfunction

		function int pending();
			return lines_due.size();
		endfunction

		function void push_bad();
			line_res_t r;
			r = '0;
			r.status = 1'b1;
			lines_due.push_back(r);
			phase = PH_DONE;
			n_bad++;
		endfunction

		function void push_line(logic [OFS_W-1:0] head);
			line_res_t r;
			r.status         = 1'b0;
			r.field1_begin   = marks[F1_BEGIN];
			r.field1_end     = marks[F1_END];
			r.field2_begin   = marks[F2_BEGIN];
			r.field2_end     = marks[F2_END];
			r.field3_present = f3_nonempty;
			r.field3_begin   = f3_nonempty ? marks[F3_BEGIN] : '0;
			r.field3_end     = f3_nonempty ? marks[F3_END] : '0;
			r.header_start   = head;
			lines_due.push_back(r);
			phase = PH_DONE;
			n_ok++;
		endfunction

		// one byte of the third field or of the line terminator
		function verdict_t third(logic [7:0] c, logic [OFS_W-1:0] o);
			if (cr_wait) begin
				cr_wait = 1'b0;
				if (c == CH_LF) begin
					marks[F3_END] = o - 1'b1;
					return V_OK;
				end
				return V_BAD;
			end
			if (c == CH_LF) begin
				marks[F3_END] = o;
				return V_OK;
			end
			if (c == CH_CR) begin
				cr_wait = 1'b1;
				return V_MORE;
			end
			if (is_ctl(c) && !is_sp(c))
				return V_BAD;
			f3_nonempty = 1'b1;
			return V_MORE;
		endfunction

		function void note_byte(logic [7:0] c, logic is_first, logic is_last);
			logic [OFS_W-1:0] o;
			verdict_t v;
			v = V_MORE;
			if (is_first) begin
				clear();
				phase = PH_LEAD;
			end
			if (phase == PH_IDLE || phase == PH_DONE)
				return;
			o = ofs;
			if (o >= MAX_LINE) begin
				push_bad();
				return;
			end
			ofs = o + 1'b1;
			case (phase)
				PH_LEAD: begin
					if (!is_lws(c)) begin
						marks[F1_BEGIN] = o;
						if (is_ctl(c))
							v = V_BAD;
						else
							phase = PH_F1;
					end
				end
				PH_F1: begin
					if (is_sp(c)) begin
						marks[F1_END] = o;
						phase = PH_GAP1;
					end else if (is_ctl(c)) begin
						v = V_BAD;
					end
				end
				PH_GAP1: begin
					if (c != CH_SP) begin
						marks[F2_BEGIN] = o;
						if (is_lws(c) || is_ctl(c))
							v = V_BAD;
						else
							phase = PH_F2;
					end
				end
				PH_F2: begin
					if (is_lws(c)) begin
						marks[F2_END] = o;
						if (c == CH_SP) begin
							phase = PH_GAP2;
						end else if (c == CH_HT) begin
							v = V_BAD;
						end else begin
							// cr or lf right after field two: empty third field
							marks[F3_BEGIN] = o;
							phase = PH_F3;
							v = third(c, o);
						end
					end else if (is_ctl(c)) begin
						v = V_BAD;
					end
				end
				PH_GAP2: begin
					if (c == CH_HT) begin
						v = V_BAD;
					end else if (c != CH_SP) begin
						marks[F3_BEGIN] = o;
						phase = PH_F3;
						v = third(c, o);
					end
				end
				default: v = third(c, o);
			endcase
			if (v == V_OK)
				push_line(o + 1'b1);
			else if (v == V_BAD || is_last)
				push_bad();
		endfunction

		function void match(string what, logic [OFS_W-1:0] want, logic [OFS_W-1:0] got);
			if (want !== got) begin
				errors++;
				$display("%t: %s mismatch, expected %0d actual %0d", $time, what, want, got);
			end
		endfunction

		function void check_line(logic status, logic [95:0] d);
			line_res_t want;
			n_checked++;
			if (lines_due.size() == 0) begin
				errors++;
				$display("%t: result with nothing expected, expected none actual status %0d",
					$time, status);
				return;
			end
			want = lines_due.pop_front();
			match("status", want.status, status);
			match("field1_begin", want.field1_begin, d[12:0]);
			match("field1_end", want.field1_end, d[25:13]);
			match("field2_begin", want.field2_begin, d[38:26]);
			match("field2_end", want.field2_end, d[51:39]);
			match("field3_present", want.field3_present, d[52]);
			match("field3_begin", want.field3_begin, d[65:53]);
			match("field3_end", want.field3_end, d[78:66]);
			match("header_start", want.header_start, d[91:79]);
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;
	logic [0:0]  s_tuser;
	logic        s_tlast;
	logic        m_tvalid;
	logic        m_tready;
	logic [95:0] m_tdata;
	logic [0:0]  m_tuser;

	line_board   board = new();
	int          burst_left = 0;
	int          fed = 0;
	int          n_buffers = 0;
	int          cycle_count = 0;
	int          n_holds = 0;
	bit          hold_rx = 1'b0;
	logic [7:0]  line_q [$];
	int          body_len;
	logic [7:0]  odd_vals [11] = '{8'h00, 8'h09, 8'h0a, 8'h0d, 8'h20, 8'h7f,
		8'h1f, 8'h01, 8'hff, 8'h80, 8'h41};

	http_start_line_splitter u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	initial clk = 1'b0;
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// values read here are the ones before the edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready)
				board.note_byte(s_tdata, s_tuser[0], s_tlast);
			if (m_tvalid && m_tready)
				board.check_line(m_tuser[0], m_tdata);
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycle_count, board.pending());
			$display("TEST FAILED");
			$finish;
		end
	end

	// receiver: changing stall pattern, plus long hold-offs on request
	initial begin : rx_side
		rx_mode_t mode;
		int left;
		int tick;
		mode = RX_FREE;
		left = 0;
		tick = 0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_rx) begin
				m_tready <= 1'b0;
				repeat (RX_HOLD) @(posedge clk);
				hold_rx = 1'b0;
				n_holds++;
			end else begin
				if (left == 0) begin
					mode = rx_mode_t'($urandom_range(0, 3));
					left = $urandom_range(32, 256);
				end
				left--;
				tick++;
				case (mode)
					RX_FREE:   m_tready <= 1'b1;
					RX_COIN:   m_tready <= 1'($urandom_range(0, 1));
					RX_SPARSE: m_tready <= (tick % 4 == 0);
					default:   m_tready <= ($urandom_range(0, 7) != 0);
				endcase
			end
		end
	end

	task automatic send_byte(input logic [7:0] c, input logic is_first, input logic is_last);
		int gap;
		if (burst_left <= 0) begin
			s_tvalid <= 1'b0;
			gap = $urandom_range(1, 6);
			repeat (gap) @(posedge clk);
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
				: $urandom_range(1, 24);
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tdata  <= c;
		s_tuser  <= is_first;
		s_tlast  <= is_last;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		fed++;
	endtask

	// stop offering and wait until every predicted result has arrived
	task automatic drain();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (board.pending() != 0);
	endtask

	task automatic send_text(input string s, input bit mark_last);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i], i == 0, mark_last && i == s.len() - 1);
		n_buffers++;
	endtask

	function automatic logic [7:0] token_byte();
		if ($urandom_range(0, 9) == 0)
			return 8'($urandom_range(128, 255));
		return 8'($urandom_range(33, 126));
	endfunction

	function automatic logic [7:0] odd_byte();
		if ($urandom_range(0, 3) == 0)
			return 8'($urandom_range(0, 255));
		return odd_vals[$urandom_range(0, 10)];
	endfunction

	function automatic logic [7:0] lws_byte();
		case ($urandom_range(0, 3))
			0:       return CH_SP;
			1:       return CH_HT;
			2:       return CH_CR;
			default: return CH_LF;
		endcase
	endfunction

	// well-formed start line with random content, then a few stray bytes
	function automatic void build_line();
		int n;
		line_q.delete();
		repeat ($urandom_range(0, 3)) line_q.push_back(lws_byte());
		repeat ($urandom_range(1, 8)) line_q.push_back(token_byte());
		line_q.push_back(($urandom_range(0, 3) == 0) ? CH_HT : CH_SP);
		repeat ($urandom_range(0, 2)) line_q.push_back(CH_SP);
		n = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 10);
		repeat (n) line_q.push_back(token_byte());
		if ($urandom_range(0, 2) != 0) begin
			line_q.push_back(CH_SP);
			repeat ($urandom_range(0, 2)) line_q.push_back(CH_SP);
			line_q.push_back(token_byte());
			repeat ($urandom_range(0, 9)) begin
				if ($urandom_range(0, 4) == 0)
					line_q.push_back($urandom_range(0, 1) ? CH_SP : CH_HT);
				else
					line_q.push_back(token_byte());
			end
		end
		if ($urandom_range(0, 1))
			line_q.push_back(CH_CR);
		line_q.push_back(CH_LF);
		body_len = line_q.size();
		repeat ($urandom_range(0, 3)) line_q.push_back(8'($urandom_range(0, 255)));
	endfunction

	task automatic send_random_buffer(input bit clean);
		int kind;
		int stop;
		int n;
		bit mark_last;
		kind = clean ? 0 : $urandom_range(0, 99);
		mark_last = 1'b1;
		if (kind >= 94) begin
			// noise buffer
			line_q.delete();
			n = $urandom_range(1, 12);
			repeat (n) line_q.push_back(8'($urandom_range(0, 255)));
			body_len = n;
			stop = n - 1;
		end else begin
			build_line();
			stop = line_q.size() - 1;
			if (kind >= 65 && kind < 80) begin
				line_q[$urandom_range(0, body_len - 1)] = odd_byte();
			end else if (kind >= 80 && kind < 88) begin
				stop = $urandom_range(0, body_len - 1);
			end else if (kind >= 88) begin
				// dropped mid-line by the next buffer start
				stop = $urandom_range(0, body_len - 1);
				mark_last = 1'b0;
			end
		end
		for (int i = 0; i <= stop; i++)
			send_byte(line_q[i], i == 0, mark_last && i == stop);
		n_buffers++;
		if (!clean && $urandom_range(0, 9) == 0) begin
			repeat ($urandom_range(1, 3))
				send_byte(8'($urandom_range(0, 255)), 1'b0, 1'($urandom_range(0, 1)));
		end
	endtask

	initial begin : main_flow
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tuser  = '0;
		s_tlast  = 1'b0;
		m_tready = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// stray bytes before any buffer has started
		send_byte(8'hff, 1'b0, 1'b0);
		send_byte(8'h00, 1'b0, 1'b1);

		send_text("GET / HTTP/1.1\015\012", 1'b1);
		send_text("\015\012 \011GET /index\012", 1'b1);
		send_text("GET\011/x y\015\012", 1'b1);
		send_text("GET \011/x\012", 1'b1);
		send_text("GET /x\011HTTP\012", 1'b1);
		send_text("GET /x  \011y\012", 1'b1);
		send_text("GET /x HTTP\015X\012", 1'b1);
		send_text("GET /x HT", 1'b1);
		send_text("GET  \012", 1'b1);
		send_text("GET /a", 1'b0);
		send_text("POST /b c\012", 1'b1);
		send_text("GET /a b\012ZZZ", 1'b1);
		send_text("G\001T / x\012", 1'b1);
		send_text("GET /\177\012", 1'b1);
		send_text("GET / a\177\012", 1'b1);
		send_text("GET /a H\011T\011\015\012", 1'b1);
		send_text("\377\200 \377 \377\012", 1'b1);
		send_text("GET /a   \015\012", 1'b1);
		// nul as the first byte of a buffer, then ignored bytes
		send_byte(8'h00, 1'b1, 1'b0);
		send_byte(8'h61, 1'b0, 1'b1);
		n_buffers++;
		drain();

		// receiver holds off while lines keep coming, so the block stalls its input
		hold_rx = 1'b1;
		repeat (12) send_random_buffer(1'b1);
		drain();

		while (fed < FEED_TARGET) begin
			send_random_buffer(1'b0);
			if ($urandom_range(0, 49) == 0)
				drain();
			if ($urandom_range(0, 199) == 0 && !hold_rx)
				hold_rx = 1'b1;
		end
		drain();
		repeat (4) @(posedge clk);

		$display("fed %0d bytes in %0d buffers, %0d long receiver hold-offs",
			fed, n_buffers, n_holds);
		$display("results checked %0d: %0d lines accepted, %0d bad requests",
			board.n_checked, board.n_ok, board.n_bad);
		if (board.errors == 0 && board.pending() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("%0d mismatches, %0d results never arrived", board.errors,
				board.pending());
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

FILE: sim.f
src/hsl_pkg.sv
src/hsl_step.sv
src/http_start_line_splitter.sv
tb/sv/tb_http_start_line_splitter.sv
